// File: rtl/core/vdss_pkg.sv
// Package for the vertex lighting pipeline: fixed-point word types, mode codes,
// register indexes and the table-limit clamp constant.
// No dependencies.
package vdss_pkg;

    typedef logic signed [31:0] word_t;   // 16.16 word, wraps modulo 2^32
    typedef logic signed [47:0] prod_t;   // low bits of a product that a dot needs

    // Shade table depth; the specular clamp sits just below TABLE_ROWS << 12
    localparam int unsigned TABLE_ROWS = 32;
    localparam int unsigned LIM_SHIFT  = 12;
    localparam int unsigned OUT_SHIFT  = 4;
    localparam word_t       SHADE_LIM  = word_t'(TABLE_ROWS << LIM_SHIFT);

    // Lighting mode codes (the unused code behaves as CMD_BOTH)
    localparam logic [1:0] CMD_DIFFUSE  = 2'd0;
    localparam logic [1:0] CMD_SPECULAR = 2'd1;
    localparam logic [1:0] CMD_BOTH     = 2'd2;
    localparam logic [1:0] CMD_SPARE    = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH   = 3'd7;

endpackage

// File: rtl/core/vertex_diffuse_specular_shader.sv
// Vertex lighting pipeline: Lambert diffuse and Phong-style specular shade per normal.
// Depends on vdss_pkg.
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   s       | in        | s_valid/s_ready      | s_cmd, s_normal_x/y/z
//   m       | out       | m_valid/m_ready      | m_shade, m_raw_shade
//
// One item per cycle sustained while m_ready allows; each item passes through the
// products, the dot sums, the 32x32 multiplier and three add/compare stages
// before m_valid. The whole pipeline advances together and holds while a
// result waits on m_ready, so a stall drops and repeats nothing.
// Synchronous active-low reset clears the valid bits and the configuration registers.
// cfg_ready is always high.
module vertex_diffuse_specular_shader (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vdss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_cmd,
    input  logic signed [17:0]                 s_normal_x,
    input  logic signed [17:0]                 s_normal_y,
    input  logic signed [17:0]                 s_normal_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [27:0]                 m_shade,
    output logic signed [31:0]                 m_raw_shade
);
    import vdss_pkg::*;

    // ---------------- configuration ----------------
    word_t       light_x_reg, light_y_reg, light_z_reg;
    word_t       view_x_reg, view_y_reg, view_z_reg;
    logic [30:0] ambient_reg;
    word_t       flash_reg;
    word_t       amb;

    assign cfg_ready = 1'b1;
    assign amb       = word_t'({1'b0, ambient_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg <= '0;
            light_y_reg <= '0;
            light_z_reg <= '0;
            view_x_reg  <= '0;
            view_y_reg  <= '0;
            view_z_reg  <= '0;
            ambient_reg <= '0;
            flash_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LIGHT_X: light_x_reg <= cfg_data;
                REG_LIGHT_Y: light_y_reg <= cfg_data;
                REG_LIGHT_Z: light_z_reg <= cfg_data;
                REG_VIEW_X:  view_x_reg  <= cfg_data;
                REG_VIEW_Y:  view_y_reg  <= cfg_data;
                REG_VIEW_Z:  view_z_reg  <= cfg_data;
                REG_AMBIENT: ambient_reg <= cfg_data[30:0];
                REG_FLASH:   flash_reg   <= cfg_data;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic pipe_en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            m_valid_reg <= v5_reg;
        end
    end

    // ---------------- stage 1: component products ----------------
    // Only bits 16..47 of a dot sum survive, so 48 product bits are kept.
    prod_t      nlx_next, nly_next, nlz_next, nvx_next, nvy_next, nvz_next;
    prod_t      lvx_next, lvy_next, lvz_next;
    prod_t      nlx_reg, nly_reg, nlz_reg, nvx_reg, nvy_reg, nvz_reg;
    prod_t      lvx_reg, lvy_reg, lvz_reg;
    logic [1:0] cmd1_reg;

    assign nlx_next = light_x_reg * s_normal_x;
    assign nly_next = light_y_reg * s_normal_y;
    assign nlz_next = light_z_reg * s_normal_z;
    assign nvx_next = view_x_reg * s_normal_x;
    assign nvy_next = view_y_reg * s_normal_y;
    assign nvz_next = view_z_reg * s_normal_z;
    assign lvx_next = light_x_reg * view_x_reg;
    assign lvy_next = light_y_reg * view_y_reg;
    assign lvz_next = light_z_reg * view_z_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            nlx_reg  <= nlx_next;
            nly_reg  <= nly_next;
            nlz_reg  <= nlz_next;
            nvx_reg  <= nvx_next;
            nvy_reg  <= nvy_next;
            nvz_reg  <= nvz_next;
            lvx_reg  <= lvx_next;
            lvy_reg  <= lvy_next;
            lvz_reg  <= lvz_next;
            cmd1_reg <= s_cmd;
        end
    end

    // ---------------- stage 2: dot sums ----------------
    prod_t      nl_sum, nv_sum, lv_sum;
    word_t      nl2_reg, nv2_reg, ldv2_reg;
    logic [1:0] cmd2_reg;

    assign nl_sum = nlx_reg + nly_reg + nlz_reg;
    assign nv_sum = nvx_reg + nvy_reg + nvz_reg;
    assign lv_sum = lvx_reg + lvy_reg + lvz_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            nl2_reg  <= nl_sum[47:16];
            nv2_reg  <= nv_sum[47:16];
            ldv2_reg <= lv_sum[47:16];
            cmd2_reg <= cmd1_reg;
        end
    end

    // ---------------- stage 3: n.v times n.l ----------------
    // Specular mode doubles n.v (wrapping) before the product.
    word_t      mul_a;
    prod_t      spec_prod_next;
    prod_t      spec_prod_reg;
    word_t      nl3_reg, ldv3_reg;
    logic [1:0] cmd3_reg;

    assign mul_a          = (cmd2_reg == CMD_SPECULAR) ? {nv2_reg[30:0], 1'b0} : nv2_reg;
    assign spec_prod_next = mul_a * nl2_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            spec_prod_reg <= spec_prod_next;
            nl3_reg       <= nl2_reg;
            ldv3_reg      <= ldv2_reg;
            cmd3_reg      <= cmd2_reg;
        end
    end

    // ---------------- stage 4: subtract l.v, prepare addends ----------------
    // Combined mode doubles after the product: bits 16..46 moved up one, zero below.
    word_t      spec_sel;
    word_t      t1_next, addend_next, diff_next;
    word_t      t1_reg, addend_reg, diff_reg;
    logic [1:0] cmd4_reg;
    logic       nl_neg4_reg;

    assign spec_sel    = (cmd3_reg == CMD_SPECULAR) ? spec_prod_reg[47:16]
                                                    : {spec_prod_reg[46:16], 1'b0};
    assign t1_next     = spec_sel - ldv3_reg;
    assign addend_next = (cmd3_reg == CMD_SPECULAR) ? amb : nl3_reg + amb;
    assign diff_next   = (nl3_reg[31] ? '0 : nl3_reg) + amb;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            t1_reg      <= t1_next;
            addend_reg  <= addend_next;
            diff_reg    <= diff_next;
            cmd4_reg    <= cmd3_reg;
            nl_neg4_reg <= nl3_reg[31];
        end
    end

    // ---------------- stage 5: flash threshold and path select ----------------
    word_t x_next, x5_reg;
    logic  spec_next, spec5_reg;

    always_comb begin
        priority if (cmd4_reg == CMD_DIFFUSE) begin
            x_next    = diff_reg;
            spec_next = 1'b0;
        end else if (nl_neg4_reg) begin
            // surface faces away: ambient only
            x_next    = amb;
            spec_next = 1'b0;
        end else begin
            x_next    = ((t1_reg < flash_reg) ? '0 : t1_reg) + addend_reg;
            spec_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            x5_reg    <= x_next;
            spec5_reg <= spec_next;
        end
    end

    // ---------------- stage 6: clamp, shift, output register ----------------
    word_t              clamped;
    logic signed [27:0] shade_next;
    word_t              raw_next;
    logic signed [27:0] m_shade_reg;
    word_t              m_raw_shade_reg;
    logic               spec_out_reg;

    assign clamped    = (spec5_reg && x5_reg >= SHADE_LIM) ? SHADE_LIM - word_t'(1) : x5_reg;
    assign shade_next = clamped[31:OUT_SHIFT];
    assign raw_next   = spec5_reg ? clamped : word_t'(shade_next);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_shade_reg     <= shade_next;
            m_raw_shade_reg <= raw_next;
            spec_out_reg    <= spec5_reg;
        end
    end

    assign m_shade     = m_shade_reg;
    assign m_raw_shade = m_raw_shade_reg;

    // ---------------- assertions ----------------
    a_spec_clamped : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && spec_out_reg |-> $signed(m_raw_shade_reg) < SHADE_LIM)
        else $error("specular result above table limit");

    a_pipe_advance : assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_en && v5_reg |=> m_valid_reg)
        else $error("item lost between last stage and output");

    a_shifted_raw : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !spec_out_reg |-> m_raw_shade_reg[31:28] == {4{m_shade_reg[27]}})
        else $error("shifted raw shade not sign extended");

endmodule
